// ----- hw/rtl/tir_pkg.sv -----
package tir_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_IN_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_IN_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_OUT_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_OUT_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_COL_RATIO  = 3'd4;
    localparam logic [2:0] CFG_ROW_RATIO  = 3'd5;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 26;
    localparam int IN_DIM_W = 10;
    localparam int OUT_DIM_W = 11;
    localparam int RATIO_W = 26;
    localparam int PIX_W = 8;
    localparam int POS_W = 10;
    localparam int WGT_W = 17;
    localparam int FRAC_W = 16;

    localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_EMIT  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic store_en;
        logic emit_start;
        logic mul_en;
        logic base_en;
        logic rd_en;
        logic vw_en;
        logic hw_en;
        logic out_load;
        logic rsel;
        logic csel;
    } tir_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } tir_status_t;

endpackage

// ----- hw/rtl/tir_if.sv -----
interface tir_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] pixel_in;
    modport source (output valid, output cmd, output pixel_in, input ready);
    modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface tir_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       last_pixel;
    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input last_pixel, output ready);
endinterface

interface tir_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [25:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/tir_ctrl.sv -----
module tir_ctrl
    import tir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_cmd,
    output logic        in_ready,
    input  tir_status_t status,
    output tir_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_BASE,
        S_RD,
        S_VW,
        S_HW,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   rsel_reg, rsel_next;
    logic   csel_reg, csel_next;

    always_comb
    begin
        state_next = state_reg;
        rsel_next  = rsel_reg;
        csel_next  = csel_reg;
        cmd        = '0;
        cmd.rsel   = rsel_reg;
        cmd.csel   = csel_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_cmd == CMD_STORE)
                begin
                    cmd.store_en = 1'b1;
                end
                else if (in_valid)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_BASE;
            end
            S_BASE:
            begin
                cmd.base_en = 1'b1;
                rsel_next   = 1'b0;
                csel_next   = 1'b0;
                state_next  = S_RD;
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_VW;
            end
            S_VW:
            begin
                cmd.vw_en = 1'b1;
                if (!rsel_reg)
                begin
                    rsel_next  = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    rsel_next  = 1'b0;
                    state_next = S_HW;
                end
            end
            S_HW:
            begin
                cmd.hw_en = 1'b1;
                if (!csel_reg)
                begin
                    csel_next  = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsel_reg  <= 1'b0;
            csel_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsel_reg  <= rsel_next;
            csel_reg  <= csel_next;
        end
    end

endmodule

// ----- hw/rtl/tir_dp.sv -----
module tir_dp
    import tir_pkg::*;
#(
    parameter int MAX_IN_DIM  = 512,
    parameter int MAX_OUT_DIM = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tir_cmd_t              cmd,
    output tir_status_t           status,
    input  logic [PIX_W-1:0]      pixel_in,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      pixel_out,
    output logic [POS_W-1:0]      out_row,
    output logic [POS_W-1:0]      out_col,
    output logic                  last_pixel
);

    localparam int DEPTH = MAX_IN_DIM * MAX_IN_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int RC_W  = $clog2(MAX_OUT_DIM);
    localparam int PROD_W = RC_W + RATIO_W;
    localparam int IDX_W  = PROD_W - FRAC_W + 1;
    localparam int SIZE_W = 2 * IN_DIM_W;

    // configuration
    logic [IN_DIM_W-1:0]  in_width_reg, in_height_reg;
    logic [OUT_DIM_W-1:0] out_width_reg, out_height_reg;
    logic [RATIO_W-1:0]   col_ratio_reg, row_ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg   <= 10'd512;
            in_height_reg  <= 10'd512;
            out_width_reg  <= 11'd512;
            out_height_reg <= 11'd512;
            col_ratio_reg  <= 26'd65536;
            row_ratio_reg  <= 26'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IN_WIDTH:   in_width_reg   <= cfg_data[IN_DIM_W-1:0];
                CFG_IN_HEIGHT:  in_height_reg  <= cfg_data[IN_DIM_W-1:0];
                CFG_OUT_WIDTH:  out_width_reg  <= cfg_data[OUT_DIM_W-1:0];
                CFG_OUT_HEIGHT: out_height_reg <= cfg_data[OUT_DIM_W-1:0];
                CFG_COL_RATIO:  col_ratio_reg  <= cfg_data;
                CFG_ROW_RATIO:  row_ratio_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturated dimensions
    logic [IN_DIM_W-1:0]  iw, ih;
    logic [OUT_DIM_W-1:0] ow, oh;
    logic [SIZE_W-1:0]    size;

    assign iw = (32'(in_width_reg) > MAX_IN_DIM) ? IN_DIM_W'(MAX_IN_DIM) : in_width_reg;
    assign ih = (32'(in_height_reg) > MAX_IN_DIM) ? IN_DIM_W'(MAX_IN_DIM) : in_height_reg;
    assign ow = (out_width_reg == '0) ? OUT_DIM_W'(1) :
                (32'(out_width_reg) > MAX_OUT_DIM) ? OUT_DIM_W'(MAX_OUT_DIM) : out_width_reg;
    assign oh = (out_height_reg == '0) ? OUT_DIM_W'(1) :
                (32'(out_height_reg) > MAX_OUT_DIM) ? OUT_DIM_W'(MAX_OUT_DIM) : out_height_reg;
    assign size = iw * ih;

    // load pointer
    logic [SIZE_W-1:0] lp_reg;
    logic [SIZE_W-1:0] wr_ptr;
    logic [SIZE_W:0]   lp_inc;

    assign wr_ptr = (lp_reg >= size) ? '0 : lp_reg;
    assign lp_inc = {1'b0, wr_ptr} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg <= '0;
        end
        else if (cmd.store_en && size != '0)
        begin
            lp_reg <= (lp_inc >= {1'b0, size}) ? '0 : lp_inc[SIZE_W-1:0];
        end
    end

    // frame store
    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.store_en && size != '0)
        begin
            mem[AW'(wr_ptr)] <= pixel_in;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // output scan position
    logic [RC_W-1:0] erow_reg, ecol_reg;
    logic [RC_W-1:0] cur_row, cur_col;
    logic            restart, cur_last, row_end, col_end;

    assign restart  = ({1'b0, erow_reg} >= (RC_W+1)'(oh)) ||
                      ({1'b0, ecol_reg} >= (RC_W+1)'(ow));
    assign cur_row  = restart ? '0 : erow_reg;
    assign cur_col  = restart ? '0 : ecol_reg;
    assign row_end  = ((RC_W+1)'(cur_row) + 1'b1) >= (RC_W+1)'(oh);
    assign col_end  = ((RC_W+1)'(cur_col) + 1'b1) >= (RC_W+1)'(ow);
    assign cur_last = row_end && col_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erow_reg <= '0;
            ecol_reg <= '0;
        end
        else if (cmd.emit_start)
        begin
            if (col_end)
            begin
                ecol_reg <= '0;
                erow_reg <= row_end ? '0 : cur_row + 1'b1;
            end
            else
            begin
                ecol_reg <= cur_col + 1'b1;
                erow_reg <= cur_row;
            end
        end
    end

    // per-pixel working registers
    logic [RC_W-1:0]     m_reg, n_reg;
    logic                last_reg;
    logic [PROD_W-1:0]   rp_reg, cp_reg;
    logic [SIZE_W-1:0]   base_reg;
    logic [8:0]          inter_reg;
    logic [9:0]          hacc_reg;

    logic [IDX_W-1:0]    ri, ci, k, l;
    logic [FRAC_W-1:0]   rf, cf;
    logic [WGT_W-1:0]    vw, hw;
    logic [SIZE_W-1:0]   row_base;
    logic [PIX_W-1:0]    vval;
    logic [8:0]          hval;
    logic [PIX_W+WGT_W-1:0] vprod;
    logic [9+WGT_W-1:0]     hprod;

    assign ri = IDX_W'(rp_reg[PROD_W-1:FRAC_W]);
    assign ci = IDX_W'(cp_reg[PROD_W-1:FRAC_W]);
    assign rf = rp_reg[FRAC_W-1:0];
    assign cf = cp_reg[FRAC_W-1:0];
    assign k  = ri + IDX_W'(cmd.rsel);
    assign l  = ci + IDX_W'(cmd.csel);
    assign vw = cmd.rsel ? WGT_W'(rf) : ONE_Q16 - WGT_W'(rf);
    assign hw = cmd.csel ? WGT_W'(cf) : ONE_Q16 - WGT_W'(cf);

    // row i+1 starts one input row after row i
    assign row_base = cmd.rsel ? base_reg + SIZE_W'(iw) : base_reg;
    assign rd_addr  = AW'(row_base + SIZE_W'(l[IN_DIM_W-1:0]));

    // taps past the input edge read as white while still inside the output size
    assign vval = (k < IDX_W'(ih)) ? rd_data_reg :
                  (k < IDX_W'(out_height_reg)) ? PIX_MAX : '0;
    assign hval = (l < IDX_W'(iw)) ? inter_reg :
                  (l < IDX_W'(out_width_reg)) ? 9'(PIX_MAX) : '0;
    assign vprod = vval * vw;
    assign hprod = hval * hw;

    always_ff @(posedge clk)
    begin
        if (cmd.emit_start)
        begin
            m_reg    <= cur_row;
            n_reg    <= cur_col;
            last_reg <= cur_last;
        end
        if (cmd.mul_en)
        begin
            rp_reg <= m_reg * row_ratio_reg;
            cp_reg <= n_reg * col_ratio_reg;
        end
        if (cmd.base_en)
        begin
            base_reg <= ri[IN_DIM_W-1:0] * iw;
        end
        if (cmd.vw_en)
        begin
            inter_reg <= (cmd.rsel ? inter_reg : 9'd0) + 9'(vprod[PIX_W+WGT_W-1:FRAC_W]);
        end
        if (cmd.hw_en)
        begin
            hacc_reg <= (cmd.csel ? hacc_reg : 10'd0) + 10'(hprod[9+WGT_W-1:FRAC_W]);
        end
    end

    // output register
    logic out_valid_reg;
    logic [PIX_W-1:0] pix_out_reg;
    logic [POS_W-1:0] orow_reg, ocol_reg;
    logic             olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pix_out_reg <= (hacc_reg > 10'(PIX_MAX)) ? PIX_MAX : hacc_reg[PIX_W-1:0];
            orow_reg    <= POS_W'(m_reg);
            ocol_reg    <= POS_W'(n_reg);
            olast_reg   <= last_reg;
        end
    end

    assign status.out_full = out_valid_reg && !out_ready;
    assign out_valid  = out_valid_reg;
    assign pixel_out  = pix_out_reg;
    assign out_row    = orow_reg;
    assign out_col    = ocol_reg;
    assign last_pixel = olast_reg;

endmodule

// ----- hw/rtl/separable_tent_image_resizer.sv -----
// Channel   Dir  Payload                                     Transfer
// in_ch     in   cmd, pixel_in                               valid & ready
// out_ch    out  pixel_out, out_row, out_col, last_pixel     valid & ready
// cfg_ch    in   index (0..5), data                          valid & ready (always ready)
//
// A store command (cmd 0) leaves ready high, so stores stream back to back.
// An emit command (cmd 1) holds the input from the accepting cycle through a multiply
// step and an address step, then for each of the two columns two frame-store reads with
// vertical weighting and one horizontal weighting step, then the load into the output
// register, which waits while the output is full. The single-port frame store is read
// one tap at a time.
// Reset clears scan position and load pointer, loads default configuration; frame store is kept.
// A stalled output holds the result; the next emit waits only if its result finds it still full.
module separable_tent_image_resizer
    import tir_pkg::*;
#(
    parameter int MAX_IN_DIM  = 512,
    parameter int MAX_OUT_DIM = 1024
)
(
    input  logic     clk,
    input  logic     rst_n,
    tir_in_if.sink   in_ch,
    tir_out_if.source out_ch,
    tir_cfg_if.sink  cfg_ch
);

    tir_cmd_t    cmd;
    tir_status_t status;

    // configuration is taken whenever offered
    assign cfg_ch.ready = 1'b1;

    tir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_cmd   (in_ch.cmd),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    tir_dp #(
        .MAX_IN_DIM  (MAX_IN_DIM),
        .MAX_OUT_DIM (MAX_OUT_DIM)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .pixel_in   (in_ch.pixel_in),
        .cfg_we     (cfg_ch.valid),
        .cfg_index  (cfg_ch.index),
        .cfg_data   (cfg_ch.data),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .pixel_out  (out_ch.pixel_out),
        .out_row    (out_ch.out_row),
        .out_col    (out_ch.out_col),
        .last_pixel (out_ch.last_pixel)
    );

endmodule
